>>> sv/plummer_potential_force_macros.svh
// ----------------------------------------------------------------------------
// Plummer force assertion macros
// Shared assertion forms for the Plummer potential and force block.
// ----------------------------------------------------------------------------
`ifndef PLUMMER_POTENTIAL_FORCE_MACROS_SVH
`define PLUMMER_POTENTIAL_FORCE_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define PPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked around reset.
`define PPF_ASSERT_AFTER(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ppf_pkg.sv
// ----------------------------------------------------------------------------
// Plummer force package
// Register indexes and fixed widths shared by the Plummer force block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppf_pkg;

  // Width of the mass and core radius registers.
  localparam int REG_BITS = 31;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MASS           = 2'd0,
    REG_CORE_RADIUS_SQ = 2'd1,
    REG_TWO_DIM        = 2'd2
  } cfg_reg_t;

endpackage

>>> sv/plummer_potential_force.sv
// ----------------------------------------------------------------------------
// Plummer potential and force
// Potential -M/sqrt(d) and acceleration -M*p/d^1.5, one particle per unstalled cycle.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  pos      pos_valid/pos_stall  pos_x, pos_y, pos_z
//  res      res_valid/res_stall  potential, acc_x/y/z, saturated, singular
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item enters per cycle while the result is not stalled. The square root
// stages, the potential divider and the acceleration dividers produce one
// result bit per stage.
// Reset clears all valid bits and loads mass = 1.0, core radius squared = 1.0.
// A stalled result freezes the whole pipeline; no item is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plummer_potential_force
  import ppf_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pos_valid,
  output logic                        pos_stall,
  input  logic signed [WORD_BITS-1:0] pos_x,
  input  logic signed [WORD_BITS-1:0] pos_y,
  input  logic signed [WORD_BITS-1:0] pos_z,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic signed [WORD_BITS-1:0] potential,
  output logic signed [WORD_BITS-1:0] acc_x,
  output logic signed [WORD_BITS-1:0] acc_y,
  output logic signed [WORD_BITS-1:0] acc_z,
  output logic                        saturated,
  output logic                        singular,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

`include "plummer_potential_force_macros.svh"

  localparam int MW  = WORD_BITS;
  localparam int SQW = 2 * MW;
  localparam int PW  = REG_BITS + FRAC_BITS;
  localparam int DW0 = ((SQW > PW) ? SQW : PW) + 2;
  localparam int DW  = DW0 + (DW0 % 2);
  localparam int SW  = DW / 2;
  localparam int PL  = (PW + 1) / 2;
  localparam int PH  = PW - PL;
  localparam int PPW = PW + MW;
  localparam int NW  = PPW + FRAC_BITS;
  localparam int NHW = NW - WORD_BITS;
  localparam int CW  = (NHW > DW) ? NHW : DW;
  localparam int CPW = (PW > WORD_BITS) ? PW : WORD_BITS;
  localparam logic [WORD_BITS-1:0] CAP_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] CAP_POS = ~CAP_NEG;

  typedef struct packed {
    logic [DW-1:0] d;
    logic [MW-1:0] mag_x;
    logic [MW-1:0] mag_y;
    logic [MW-1:0] mag_z;
    logic          neg_x;
    logic          neg_y;
    logic          neg_z;
    logic          two_dim;
    logic          zero_d;
  } geo_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] pot;
    logic                 pot_sat;
    logic                 two_dim;
    logic                 zero_d;
    logic                 ovf_x;
    logic                 neg_x;
    logic                 neg_y;
    logic                 neg_z;
  } tail_t;

  // Configuration registers
  logic [REG_BITS-1:0] mass;
  logic [REG_BITS-1:0] core_radius_sq;
  logic                two_dim;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass           <= REG_BITS'(1) << FRAC_BITS;
      core_radius_sq <= REG_BITS'(1) << FRAC_BITS;
      two_dim        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MASS:           mass           <= cfg_data[REG_BITS-1:0];
        REG_CORE_RADIUS_SQ: core_radius_sq <= cfg_data[REG_BITS-1:0];
        REG_TWO_DIM:        two_dim        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en        = !(res_valid && res_stall);
  assign pos_stall = res_valid && res_stall;

  // Stage 1: magnitudes and signs
  logic [WORD_BITS-1:0] ux, uy, uz;
  logic                 v1, td1;
  logic [MW-1:0]        mag1_x, mag1_y, mag1_z;
  logic                 neg1_x, neg1_y, neg1_z;

  assign ux = pos_x;
  assign uy = pos_y;
  assign uz = pos_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pos_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      td1    <= two_dim;
      neg1_x <= ux[WORD_BITS-1];
      neg1_y <= uy[WORD_BITS-1];
      neg1_z <= uz[WORD_BITS-1] && !two_dim;
      mag1_x <= ux[WORD_BITS-1] ? (~ux + 1'b1) : ux;
      mag1_y <= uy[WORD_BITS-1] ? (~uy + 1'b1) : uy;
      if (two_dim) begin
        mag1_z <= '0;
      end else begin
        mag1_z <= uz[WORD_BITS-1] ? (~uz + 1'b1) : uz;
      end
    end
  end

  // Stage 2: squares
  logic           v2;
  geo_t           g2;
  logic [SQW-1:0] sq_x, sq_y, sq_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x       <= mag1_x * mag1_x;
      sq_y       <= mag1_y * mag1_y;
      sq_z       <= mag1_z * mag1_z;
      g2.d       <= '0;
      g2.mag_x   <= mag1_x;
      g2.mag_y   <= mag1_y;
      g2.mag_z   <= mag1_z;
      g2.neg_x   <= neg1_x;
      g2.neg_y   <= neg1_y;
      g2.neg_z   <= neg1_z;
      g2.two_dim <= td1;
      g2.zero_d  <= 1'b0;
    end
  end

  // Stage 3: denominator
  logic v3;
  geo_t g3;
  geo_t g3_next;
  geo_t g3_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_comb begin
    g3_next   = g2;
    g3_next.d = DW'({core_radius_sq, {FRAC_BITS{1'b0}}}) + DW'(sq_x) + DW'(sq_y)
                + DW'(sq_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g3 <= g3_next;
    end
  end

  always_comb begin
    g3_in        = g3;
    g3_in.zero_d = (g3.d == '0);
  end

  // Square root: one root bit per stage
  logic          sq_v [SW];
  logic [DW-1:0] sq_x_r [SW];
  logic [DW-1:0] sq_r [SW];
  geo_t          sq_g [SW];

  genvar j;
  generate
    for (j = 0; j < SW; j++) begin : g_sqrt
      localparam logic [DW-1:0] BIT = {{(DW-1){1'b0}}, 1'b1} << (2 * (SW - 1 - j));
      logic          v_in;
      logic [DW-1:0] x_in;
      logic [DW-1:0] r_in;
      geo_t          g_in;
      logic [DW-1:0] t;
      logic          ge;

      if (j == 0) begin : g_first
        assign v_in = v3;
        assign x_in = g3.d;
        assign r_in = '0;
        assign g_in = g3_in;
      end else begin : g_next
        assign v_in = sq_v[j-1];
        assign x_in = sq_x_r[j-1];
        assign r_in = sq_r[j-1];
        assign g_in = sq_g[j-1];
      end

      assign t  = r_in + BIT;
      assign ge = (x_in >= t);

      always_ff @(posedge clk) begin
        if (rst) begin
          sq_v[j] <= 1'b0;
        end else if (en) begin
          sq_v[j] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sq_x_r[j] <= ge ? (x_in - t) : x_in;
          sq_r[j]   <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
          sq_g[j]   <= g_in;
        end
      end
    end
  endgenerate

  // Potential magnitude: floor(M * 2^F / S)
  logic          v4;
  logic [PW-1:0] pm4;
  geo_t          g4;

  ppf_divpipe #(
    .QB  (PW),
    .DVW (SW),
    .SBW ($bits(geo_t))
  ) u_pm_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v[SW-1]),
    .rem_in    ('0),
    .num_in    ({mass, {FRAC_BITS{1'b0}}}),
    .div_in    (sq_r[SW-1][SW-1:0]),
    .side_in   (sq_g[SW-1]),
    .out_valid (v4),
    .quo       (pm4),
    .side_out  (g4)
  );

  // Multiply stages: pm * |p| in two halves, then recombined
  logic          v_m1, v_m2, v_m3;
  logic [PW-1:0] pm_m1, pm_m2;
  geo_t          g_m1, g_m2;
  logic [MW-1:0] mag4 [3];
  logic          neg_m2 [3];

  assign mag4[0]   = g4.mag_x;
  assign mag4[1]   = g4.mag_y;
  assign mag4[2]   = g4.mag_z;
  assign neg_m2[0] = g_m2.neg_x;
  assign neg_m2[1] = g_m2.neg_y;
  assign neg_m2[2] = g_m2.neg_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1 <= 1'b0;
      v_m2 <= 1'b0;
      v_m3 <= 1'b0;
    end else if (en) begin
      v_m1 <= v4;
      v_m2 <= v_m1;
      v_m3 <= v_m2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_m1 <= pm4;
      g_m1  <= g4;
      pm_m2 <= pm_m1;
      g_m2  <= g_m1;
    end
  end

  logic [PL+MW-1:0] lo_m1 [3];
  logic [PH+MW-1:0] hi_m1 [3];
  logic [PPW-1:0]   prod_m2 [3];
  logic [DW-1:0]    rem_m3 [3];
  logic [WORD_BITS-1:0] nlo_m3 [3];
  logic             ovf_m3 [3];
  logic             neg_m3 [3];

  genvar k;
  generate
    for (k = 0; k < 3; k++) begin : g_lane
      logic [NW-1:0]  nfull;
      logic [NHW-1:0] nhi;

      assign nfull = {prod_m2[k], {FRAC_BITS{1'b0}}};
      assign nhi   = nfull[NW-1:WORD_BITS];

      always_ff @(posedge clk) begin
        if (en) begin
          lo_m1[k]   <= pm4[PL-1:0] * mag4[k];
          hi_m1[k]   <= pm4[PW-1:PL] * mag4[k];
          prod_m2[k] <= PPW'(lo_m1[k]) + (PPW'(hi_m1[k]) << PL);
          rem_m3[k]  <= DW'(nhi);
          nlo_m3[k]  <= nfull[WORD_BITS-1:0];
          // Quotient would need more than WORD_BITS bits: always clipped.
          ovf_m3[k]  <= (CW'(nhi) >= CW'(g_m2.d));
          neg_m3[k]  <= neg_m2[k];
        end
      end
    end
  endgenerate

  function automatic logic [WORD_BITS:0] signed_word(
    input logic [WORD_BITS-1:0] q,
    input logic                 big,
    input logic                 neg
  );
    logic [WORD_BITS-1:0] cap;
    logic [WORD_BITS-1:0] m;
    logic                 clip;
    cap  = neg ? CAP_NEG : CAP_POS;
    clip = big || (q > cap);
    m    = clip ? cap : q;
    return {clip, (neg ? (~m + 1'b1) : m)};
  endfunction

  // Potential is settled here and rides along with the x lane.
  logic [WORD_BITS:0] pot_w;
  tail_t              tail_m3;
  logic [DW-1:0]      d_m3;

  assign pot_w = signed_word(pm_m2[WORD_BITS-1 < PW ? WORD_BITS-1 : PW-1 : 0],
                             (CPW'(pm_m2) > CPW'(CAP_NEG)), 1'b1);

  always_ff @(posedge clk) begin
    if (en) begin
      d_m3            <= g_m2.d;
      tail_m3.pot     <= pot_w[WORD_BITS-1:0];
      tail_m3.pot_sat <= pot_w[WORD_BITS];
      tail_m3.two_dim <= g_m2.two_dim;
      tail_m3.zero_d  <= g_m2.zero_d;
      tail_m3.ovf_x   <= 1'b0;
      tail_m3.neg_x   <= 1'b0;
      tail_m3.neg_y   <= 1'b0;
      tail_m3.neg_z   <= 1'b0;
    end
  end

  tail_t tail_in;
  always_comb begin
    tail_in       = tail_m3;
    tail_in.ovf_x = ovf_m3[0];
    tail_in.neg_x = neg_m3[0];
    tail_in.neg_y = neg_m3[1];
    tail_in.neg_z = neg_m3[2];
  end

  // Acceleration dividers: floor(pm * |p| * 2^F / D)
  logic                 v_dx, v_dy, v_dz;
  logic [WORD_BITS-1:0] q_x, q_y, q_z;
  tail_t                tail_d;
  logic                 ovf_dy, ovf_dz;

  ppf_divpipe #(
    .QB  (WORD_BITS),
    .DVW (DW),
    .SBW ($bits(tail_t))
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_m3),
    .rem_in    (rem_m3[0]),
    .num_in    (nlo_m3[0]),
    .div_in    (d_m3),
    .side_in   (tail_in),
    .out_valid (v_dx),
    .quo       (q_x),
    .side_out  (tail_d)
  );

  ppf_divpipe #(
    .QB  (WORD_BITS),
    .DVW (DW),
    .SBW (1)
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_m3),
    .rem_in    (rem_m3[1]),
    .num_in    (nlo_m3[1]),
    .div_in    (d_m3),
    .side_in   (ovf_m3[1]),
    .out_valid (v_dy),
    .quo       (q_y),
    .side_out  (ovf_dy)
  );

  ppf_divpipe #(
    .QB  (WORD_BITS),
    .DVW (DW),
    .SBW (1)
  ) u_div_z (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_m3),
    .rem_in    (rem_m3[2]),
    .num_in    (nlo_m3[2]),
    .div_in    (d_m3),
    .side_in   (ovf_m3[2]),
    .out_valid (v_dz),
    .quo       (q_z),
    .side_out  (ovf_dz)
  );

  // Output register
  logic [WORD_BITS:0] ax_w, ay_w, az_w;

  assign ax_w = signed_word(q_x, tail_d.ovf_x, !tail_d.neg_x);
  assign ay_w = signed_word(q_y, ovf_dy, !tail_d.neg_y);
  assign az_w = signed_word(q_z, ovf_dz, !tail_d.neg_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= v_dx && v_dy && v_dz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tail_d.zero_d) begin
        potential <= '0;
        acc_x     <= '0;
        acc_y     <= '0;
        acc_z     <= '0;
        saturated <= 1'b0;
        singular  <= 1'b1;
      end else begin
        potential <= tail_d.pot;
        acc_x     <= ax_w[WORD_BITS-1:0];
        acc_y     <= ay_w[WORD_BITS-1:0];
        acc_z     <= tail_d.two_dim ? '0 : az_w[WORD_BITS-1:0];
        saturated <= tail_d.pot_sat || ax_w[WORD_BITS] || ay_w[WORD_BITS]
                     || (az_w[WORD_BITS] && !tail_d.two_dim);
        singular  <= 1'b0;
      end
    end
  end

  // Checks
  `PPF_ASSERT_IMPL(a_pot_not_positive, res_valid,
                   potential[WORD_BITS-1] || potential == '0,
                   "potential is positive")
  `PPF_ASSERT_IMPL(a_singular_zero, res_valid && singular,
                   potential == '0 && acc_x == '0 && acc_y == '0 && acc_z == '0
                   && !saturated,
                   "singular item has nonzero outputs")
  `PPF_ASSERT_IMPL(a_zero_pot_zero_acc, res_valid && potential == '0,
                   acc_x == '0 && acc_y == '0 && acc_z == '0,
                   "acceleration without potential")
  `PPF_ASSERT_AFTER(a_reset_clears, rst, !res_valid && !pos_stall,
                    "result valid after reset")

endmodule

>>> sv/ppf_divpipe.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; a side vector travels with each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppf_divpipe #(
  parameter int QB  = 32,
  parameter int DVW = 66,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [DVW-1:0] rem_in,
  input  logic [QB-1:0]  num_in,
  input  logic [DVW-1:0] div_in,
  input  logic [SBW-1:0] side_in,
  output logic           out_valid,
  output logic [QB-1:0]  quo,
  output logic [SBW-1:0] side_out
);

  logic           vld  [QB];
  logic [DVW-1:0] rem  [QB];
  logic [DVW-1:0] dvs  [QB];
  logic [QB-1:0]  num  [QB];
  logic [QB-1:0]  qt   [QB];
  logic [SBW-1:0] side [QB];

  genvar i;
  generate
    for (i = 0; i < QB; i++) begin : g_step
      logic           v_in;
      logic [DVW-1:0] r_in;
      logic [DVW-1:0] d_in;
      logic [QB-1:0]  n_in;
      logic [QB-1:0]  q_in;
      logic [SBW-1:0] s_in;
      logic [DVW:0]   trial;
      logic [DVW:0]   diff;
      logic           take;

      if (i == 0) begin : g_first
        assign v_in = in_valid;
        assign r_in = rem_in;
        assign d_in = div_in;
        assign n_in = num_in;
        assign q_in = '0;
        assign s_in = side_in;
      end else begin : g_next
        assign v_in = vld[i-1];
        assign r_in = rem[i-1];
        assign d_in = dvs[i-1];
        assign n_in = num[i-1];
        assign q_in = qt[i-1];
        assign s_in = side[i-1];
      end

      // The partial remainder stays below the divisor, so the trial fits.
      assign trial = {r_in, n_in[QB-1]};
      assign diff  = trial - {1'b0, d_in};
      assign take  = (trial >= {1'b0, d_in});

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (en) begin
          vld[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[i]  <= take ? diff[DVW-1:0] : trial[DVW-1:0];
          dvs[i]  <= d_in;
          num[i]  <= {n_in[QB-2:0], 1'b0};
          qt[i]   <= {q_in[QB-2:0], take};
          side[i] <= s_in;
        end
      end
    end
  endgenerate

  assign out_valid = vld[QB-1];
  assign quo       = qt[QB-1];
  assign side_out  = side[QB-1];

endmodule
